/* design/nsp_pkg.sv */
package nsp_pkg;

   localparam int SCORE_BITS    = 8;
   localparam int NOTE_BITS     = 8;
   localparam int VEL_BITS      = 8;
   localparam int OUT_TICK_BITS = 32;
   localparam int KIND_BITS     = 2;
   localparam int CAUSE_BITS    = 2;
   localparam int CSR_IDX_BITS  = 8;
   localparam int CSR_DATA_BITS = 8;
   localparam int CHUNK_BITS    = 6;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_BITS-1:0] KIND_NOTE_OFF = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_NOTE_ON  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_ENDED    = 2'd2;

   localparam logic [CAUSE_BITS-1:0] CAUSE_END_CODE  = 2'd0;
   localparam logic [CAUSE_BITS-1:0] CAUSE_RESERVED  = 2'd1;
   localparam logic [CAUSE_BITS-1:0] CAUSE_TRUNCATED = 2'd2;
   localparam logic [CAUSE_BITS-1:0] CAUSE_EXHAUSTED = 2'd3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_NOTE_ON_VEL  = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NOTE_OFF_VEL = 8'd1;

   localparam logic [5:0]          SUB_END     = 6'h3E;
   localparam logic [5:0]          SUB_EXT     = 6'h3F;
   localparam logic [VEL_BITS-1:0] VEL_DEFAULT = 8'd127;

   typedef struct packed {
      logic                     has_note;
      logic                     note_on;
      logic [NOTE_BITS-1:0]     note;
      logic [VEL_BITS-1:0]      vel;
      logic                     has_end;
      logic [CAUSE_BITS-1:0]    cause;
      logic [OUT_TICK_BITS-1:0] tick;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

endpackage

/* design/nsp_req_if.sv */
interface nsp_req_if import nsp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [SCORE_BITS-1:0] score_byte;
   logic                  last_byte;

   modport source(output valid, score_byte, last_byte, input ready);
   modport sink(input valid, score_byte, last_byte, output ready);
endinterface

/* design/nsp_rsp_if.sv */
interface nsp_rsp_if import nsp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_BITS-1:0]     event_kind;
   logic [NOTE_BITS-1:0]     note_number;
   logic [VEL_BITS-1:0]      velocity;
   logic [OUT_TICK_BITS-1:0] due_tick;
   logic [CAUSE_BITS-1:0]    end_cause;
   logic                     last_of_run;

   modport source(output valid, event_kind, note_number, velocity, due_tick, end_cause,
                  last_of_run, input ready);
   modport sink(input valid, event_kind, note_number, velocity, due_tick, end_cause,
                last_of_run, output ready);
endinterface

/* design/nsp_csr_if.sv */
interface nsp_csr_if import nsp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] wdata;

   modport source(output valid, index, wdata, input ready);
   modport sink(input valid, index, wdata, output ready);
endinterface

/* design/nsp_front.sv */
module nsp_front import nsp_pkg::*; #(
   parameter int MAX_DELTA_CHUNKS = 4,
   parameter int TICK_BITS        = 32
) (
   input  logic    clock,
   input  logic    reset,
   nsp_req_if.sink req_chan,
   nsp_csr_if.sink csr_chan,
   input  logic    q_full,
   output logic    push,
   output cmd_type push_cmd
);

   localparam int DELTA_BITS = CHUNK_BITS * MAX_DELTA_CHUNKS;
   localparam int CC_BITS    = $clog2(MAX_DELTA_CHUNKS + 1);

   typedef enum logic [1:0] {
      MODE_DELTA,
      MODE_DISPATCH,
      MODE_NOTE,
      MODE_VEL
   } mode_type;

   mode_type              mode_ff, mode_in, mode_eff;
   logic                  pend_on_ff, pend_on_in;
   logic [NOTE_BITS-1:0]  pend_note_ff, pend_note_in;
   logic [DELTA_BITS-1:0] acc_ff, acc_in, acc_eff, acc_new;
   logic [CC_BITS-1:0]    cc_ff, cc_in, cc_eff, cc_new;
   logic [TICK_BITS-1:0]  tick_ff, tick_in;
   logic                  done_ff, done_in;
   logic                  cfg_on_vel_ff, cfg_off_vel_ff;
   logic                  accept, restart, need_vel, b_on;
   logic [SCORE_BITS-1:0] b;
   logic                  last;
   logic [5:0]            sub;
   logic [NOTE_BITS-1:0]  note_now;
   cmd_type               cmd;

   assign req_chan.ready = !q_full;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.score_byte;
   assign last           = req_chan.last_byte;
   assign b_on           = b[6];
   assign sub            = b[5:0];

   always_comb begin
      restart  = (mode_ff == MODE_DISPATCH) && !b[7];
      mode_eff = restart ? MODE_DELTA : mode_ff;
      cc_eff   = restart ? '0 : cc_ff;
      acc_eff  = restart ? '0 : acc_ff;
      acc_new  = acc_eff;
      for (int i = 0; i < MAX_DELTA_CHUNKS; i++) begin
         if (cc_eff == CC_BITS'(i)) begin
            acc_new[CHUNK_BITS*i +: CHUNK_BITS] = b[5:0];
         end
      end
      cc_new = cc_eff + CC_BITS'(1);

      mode_in      = mode_eff;
      pend_on_in   = pend_on_ff;
      pend_note_in = pend_note_ff;
      acc_in       = acc_eff;
      cc_in        = cc_eff;
      tick_in      = tick_ff;
      done_in      = done_ff;
      note_now     = pend_note_ff;
      need_vel     = 1'b0;

      cmd          = '0;
      cmd.note_on  = pend_on_ff;

      unique case (mode_eff)
         MODE_DELTA: begin
            if (!b[6] || (cc_new >= CC_BITS'(MAX_DELTA_CHUNKS)) || last) begin
               tick_in = tick_ff + TICK_BITS'(acc_new);
               acc_in  = '0;
               cc_in   = '0;
               mode_in = MODE_DISPATCH;
            end else begin
               acc_in = acc_new;
               cc_in  = cc_new;
            end
            if (last) begin
               cmd.has_end = 1'b1;
               cmd.cause   = CAUSE_EXHAUSTED;
            end
         end
         MODE_DISPATCH: begin
            if (sub == SUB_END) begin
               cmd.has_end = 1'b1;
               cmd.cause   = b_on ? CAUSE_RESERVED : CAUSE_END_CODE;
            end else if (sub == SUB_EXT) begin
               pend_on_in = b_on;
               mode_in    = MODE_NOTE;
               if (last) begin
                  cmd.has_end = 1'b1;
                  cmd.cause   = CAUSE_TRUNCATED;
               end
            end else begin
               pend_on_in   = b_on;
               pend_note_in = NOTE_BITS'(sub);
               note_now     = NOTE_BITS'(sub);
               need_vel     = b_on ? cfg_on_vel_ff : cfg_off_vel_ff;
               cmd.note_on  = b_on;
            end
         end
         MODE_NOTE: begin
            pend_note_in = b;
            note_now     = b;
            need_vel     = pend_on_ff ? cfg_on_vel_ff : cfg_off_vel_ff;
         end
         MODE_VEL: begin
            cmd.has_note = 1'b1;
            cmd.vel      = pend_on_ff ? b : '0;
            mode_in      = MODE_DISPATCH;
            if (last) begin
               cmd.has_end = 1'b1;
               cmd.cause   = CAUSE_EXHAUSTED;
            end
         end
         default: begin
            mode_in = MODE_DELTA;
         end
      endcase

      // note known in this byte: wait for velocity or report now
      if ((mode_eff == MODE_NOTE) ||
          ((mode_eff == MODE_DISPATCH) && (sub != SUB_END) && (sub != SUB_EXT))) begin
         if (need_vel) begin
            mode_in = MODE_VEL;
            if (last) begin
               cmd.has_end = 1'b1;
               cmd.cause   = CAUSE_TRUNCATED;
            end
         end else begin
            cmd.has_note = 1'b1;
            cmd.vel      = cmd.note_on ? VEL_DEFAULT : '0;
            mode_in      = MODE_DISPATCH;
            if (last) begin
               cmd.has_end = 1'b1;
               cmd.cause   = CAUSE_EXHAUSTED;
            end
         end
      end

      cmd.note = note_now;
      cmd.tick = OUT_TICK_BITS'(tick_in);
      if (cmd.has_end) begin
         done_in = 1'b1;
      end
   end

   assign push     = accept && !done_ff && (cmd.has_note || cmd.has_end);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_DELTA;
         pend_on_ff     <= 1'b0;
         pend_note_ff   <= '0;
         acc_ff         <= '0;
         cc_ff          <= '0;
         tick_ff        <= '0;
         done_ff        <= 1'b0;
         cfg_on_vel_ff  <= 1'b0;
         cfg_off_vel_ff <= 1'b0;
      end else begin
         if (accept && !done_ff) begin
            mode_ff      <= mode_in;
            pend_on_ff   <= pend_on_in;
            pend_note_ff <= pend_note_in;
            acc_ff       <= acc_in;
            cc_ff        <= cc_in;
            tick_ff      <= tick_in;
            done_ff      <= done_in;
         end
         if (csr_chan.valid && csr_chan.ready) begin
            unique case (csr_chan.index)
               CSR_NOTE_ON_VEL:  cfg_on_vel_ff  <= csr_chan.wdata[0];
               CSR_NOTE_OFF_VEL: cfg_off_vel_ff <= csr_chan.wdata[0];
               default: ;
            endcase
         end
      end
   end

`ifndef SYNTHESIS
   a_no_push_after_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !push)
      else $error("word queued after playback ended");

   a_end_sets_done: assert property (@(posedge clock) disable iff (reset)
      (push && push_cmd.has_end) |=> done_ff)
      else $error("end result did not stop the parser");

   a_chunks_bounded: assert property (@(posedge clock) disable iff (reset)
      cc_ff < CC_BITS'(MAX_DELTA_CHUNKS))
      else $error("delta chunk count out of range");
`endif

endmodule

/* design/nsp_queue.sv */
module nsp_queue import nsp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  push_cmd,
   input  logic     pop,
   output logic     full,
   output head_type head
);

   cmd_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff;

   assign full       = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_BITS'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_BITS'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

/* design/nsp_back.sv */
module nsp_back import nsp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  head_type  head,
   output logic      pop,
   nsp_rsp_if.source rsp_chan
);

   logic phase_ff;
   logic is_note, is_last, fire;

   assign is_note = head.cmd.has_note && !phase_ff;
   assign is_last = !(is_note && head.cmd.has_end);
   assign fire    = rsp_chan.valid && rsp_chan.ready;
   assign pop     = fire && is_last;

   assign rsp_chan.valid       = head.valid;
   assign rsp_chan.event_kind  = is_note ? (head.cmd.note_on ? KIND_NOTE_ON : KIND_NOTE_OFF)
                                         : KIND_ENDED;
   assign rsp_chan.note_number = is_note ? head.cmd.note : '0;
   assign rsp_chan.velocity    = is_note ? head.cmd.vel : '0;
   assign rsp_chan.due_tick    = head.cmd.tick;
   assign rsp_chan.end_cause   = is_note ? CAUSE_END_CODE : head.cmd.cause;
   assign rsp_chan.last_of_run = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= !is_last;
      end
   end

`ifndef SYNTHESIS
   a_phase_needs_end: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (head.valid && head.cmd.has_note && head.cmd.has_end))
      else $error("second word pending without an end result");

   a_split_then_end: assert property (@(posedge clock) disable iff (reset)
      (fire && !is_last) |=> (rsp_chan.valid && rsp_chan.event_kind == KIND_ENDED))
      else $error("note word not followed by end word");
`endif

endmodule

/* design/note_score_stream_parser_top.sv */
// Note score body parser. Takes one score word per cycle on req_chan while
// the queue is not full and reports note-off, note-on and playback-ended
// results on rsp_chan, each with the accumulated due tick; comparing it
// against the system tick is left to the consumer. The result port moves
// one word per cycle while rsp_chan.ready is high, so a byte that yields
// both a note and an end result needs two result words. A four-entry queue
// between the parser and the result stage absorbs that, and req_chan.ready
// drops only while the queue is full. A result is registered in the queue
// when its byte is taken and is shown on rsp_chan from there. Configuration
// writes on csr_chan are always ready, and no clearing pass follows reset.
// After the end result every further byte taken is dropped until reset.
module note_score_stream_parser_top import nsp_pkg::*; #(
   parameter int MAX_DELTA_CHUNKS = 4,
   parameter int TICK_BITS        = 32
) (
   input  logic      clock,
   input  logic      reset,
   nsp_req_if.sink   req_chan,
   nsp_rsp_if.source rsp_chan,
   nsp_csr_if.sink   csr_chan
);

   logic     push, pop, q_full;
   cmd_type  push_cmd;
   head_type head;

   nsp_front #(
      .MAX_DELTA_CHUNKS(MAX_DELTA_CHUNKS),
      .TICK_BITS       (TICK_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .csr_chan(csr_chan),
      .q_full  (q_full),
      .push    (push),
      .push_cmd(push_cmd)
   );

   nsp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .full    (q_full),
      .head    (head)
   );

   nsp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_chan(rsp_chan)
   );

endmodule
